// ===== sv/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime tester.
`default_nettype none

package tdpt_pkg;

   localparam int NUM_WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic step;
      logic finish;
      logic verdict;
   } cmd_type;

   typedef struct packed {
      logic le_one;
      logic is_two;
      logic is_odd;
      logic div_done;
      logic quo_lt_div;
      logic rem_zero;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/tdpt_divider.sv =====
// Iterative restoring divider that resolves one quotient bit per cycle.
`default_nettype none

module tdpt_divider #(
   parameter int WIDTH = tdpt_pkg::NUM_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient,
   output logic [WIDTH-1:0]      remainder
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             running_ff, running_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   rem_shift;
   logic [WIDTH:0]   rem_diff;

   assign rem_shift = {rem_ff, quo_ff[WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      den_in     = den_ff;
      count_in   = count_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         den_in     = divisor;
         count_in   = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + CW'(1);
         if (count_ff == CW'(WIDTH - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/tdpt_datapath.sv =====
// Datapath holding the candidate, the trial divisor, the divider and the result register.
`default_nettype none

module tdpt_datapath #(
   parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tdpt_pkg::cmd_type    cmd,
   input  wire logic [NUM_WIDTH-1:0] req_candidate,
   output tdpt_pkg::status_type      status,
   output logic                      rsp_valid,
   output logic                      rsp_is_prime
);

   logic [NUM_WIDTH-1:0] cand_ff, cand_in;
   logic [NUM_WIDTH-1:0] div_ff, div_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_is_prime_ff, rsp_is_prime_in;
   logic                 div_done;
   logic [NUM_WIDTH-1:0] quotient;
   logic [NUM_WIDTH-1:0] remainder;

   tdpt_divider #(
      .WIDTH(NUM_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .done     (div_done),
      .quotient (quotient),
      .remainder(remainder)
   );

   always_comb begin
      cand_in         = cand_ff;
      div_in          = div_ff;
      rsp_valid_in    = cmd.finish;
      rsp_is_prime_in = rsp_is_prime_ff;
      if (cmd.load) begin
         cand_in = req_candidate;
         div_in  = NUM_WIDTH'(3);
      end else if (cmd.step) begin
         div_in = div_ff + NUM_WIDTH'(2);
      end
      if (cmd.finish) begin
         rsp_is_prime_in = cmd.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff         <= cand_in;
      div_ff          <= div_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   always_comb begin
      status.le_one     = (cand_ff <= NUM_WIDTH'(1));
      status.is_two     = (cand_ff == NUM_WIDTH'(2));
      status.is_odd     = cand_ff[0];
      status.div_done   = div_done;
      status.quo_lt_div = (quotient < div_ff);
      status.rem_zero   = (remainder == '0);
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

endmodule

`default_nettype wire

// ===== sv/tdpt_controller.sv =====
// Controller state machine that sequences the trial divisions.
`default_nettype none

module tdpt_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire tdpt_pkg::status_type status,
   output logic                      busy,
   output tdpt_pkg::cmd_type         cmd
);

   tdpt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tdpt_pkg::ST_CHECK;
            end
         end
         tdpt_pkg::ST_CHECK: begin
            if (status.le_one || status.is_two || !status.is_odd) begin
               state_in = tdpt_pkg::ST_IDLE;
            end else begin
               state_in = tdpt_pkg::ST_LAUNCH;
            end
         end
         tdpt_pkg::ST_LAUNCH: begin
            state_in = tdpt_pkg::ST_DIVIDE;
         end
         tdpt_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = tdpt_pkg::ST_EVAL;
            end
         end
         tdpt_pkg::ST_EVAL: begin
            if (status.quo_lt_div || status.rem_zero) begin
               state_in = tdpt_pkg::ST_IDLE;
            end else begin
               state_in = tdpt_pkg::ST_LAUNCH;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         tdpt_pkg::ST_CHECK: begin
            if (status.le_one || status.is_two || !status.is_odd) begin
               cmd.finish  = 1'b1;
               cmd.verdict = status.is_two;
            end
         end
         tdpt_pkg::ST_LAUNCH: begin
            cmd.div_start = 1'b1;
         end
         tdpt_pkg::ST_DIVIDE: begin
            cmd = '0;
         end
         tdpt_pkg::ST_EVAL: begin
            if (status.quo_lt_div) begin
               cmd.finish  = 1'b1;
               cmd.verdict = 1'b1;
            end else if (status.rem_zero) begin
               cmd.finish  = 1'b1;
               cmd.verdict = 1'b0;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester.
// A candidate transfers when start is high and busy is low. Zero, one, two and
// the other even values are answered from the check state, without a trial. An
// odd candidate of three or more is divided by 3, 5, 7 and so on; each trial
// runs on the shared divider, which resolves one quotient bit per cycle, and
// the search ends at the first zero remainder or once the quotient falls below
// the divisor. The worst case, a large prime, takes about 2^(NUM_WIDTH/2-1)
// trials. The verdict appears on rsp_is_prime for exactly one cycle with
// rsp_valid high and must be taken in that cycle, since the receiver cannot
// stall the block.
`default_nettype none

module trial_division_prime_test #(
   parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [NUM_WIDTH-1:0] req_candidate,
   output logic                      rsp_valid,
   output logic                      rsp_is_prime
);

   tdpt_pkg::cmd_type    cmd;
   tdpt_pkg::status_type status;

   tdpt_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .status(status),
      .busy  (busy),
      .cmd   (cmd)
   );

   tdpt_datapath #(
      .NUM_WIDTH(NUM_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_candidate(req_candidate),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

endmodule

`default_nettype wire
